[rtl/core/multi_channel_soft_timer_bank_defines.svh]
`ifndef MULTI_CHANNEL_SOFT_TIMER_BANK_DEFINES_SVH
`define MULTI_CHANNEL_SOFT_TIMER_BANK_DEFINES_SVH

// check that a condition implies a consequence on the same edge
`define MCSTB_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mcstb implication violated");

// check that a condition never holds
`define MCSTB_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error("mcstb forbidden condition");

`endif

[rtl/core/mcstb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package mcstb_pkg;

    localparam int unsigned DEF_NUM_TIMERS = 8;
    localparam int unsigned IDX_W = 3;
    localparam int unsigned IDX_SPAN = 8;
    localparam int unsigned TICK_W = 24;
    localparam int unsigned CNT_W = 32;
    localparam int unsigned NUM_UNITS = 4;

    localparam logic [3:0] OP_TICK = 4'd0;
    localparam logic [3:0] OP_START = 4'd1;
    localparam logic [3:0] OP_INIT = 4'd2;
    localparam logic [3:0] OP_SET = 4'd3;
    localparam logic [3:0] OP_PAUSE = 4'd4;
    localparam logic [3:0] OP_PLAY = 4'd5;
    localparam logic [3:0] OP_READ = 4'd6;
    localparam logic [3:0] OP_READ_CLR = 4'd7;
    localparam logic [3:0] OP_RAISE = 4'd8;
    localparam logic [3:0] OP_CLEAR = 4'd9;
    localparam logic [3:0] OP_NOP = 4'hF;

    localparam logic [TICK_W-1:0] TICKS_RST_0 = 24'd8;
    localparam logic [TICK_W-1:0] TICKS_RST_1 = 24'd80;
    localparam logic [TICK_W-1:0] TICKS_RST_2 = 24'd800;
    localparam logic [TICK_W-1:0] TICKS_RST_3 = 24'd8000;

    typedef struct packed {
        logic             valid;
        logic [3:0]       op;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] cnt;
        logic [CNT_W-1:0] rel;
        logic [1:0]       unit;
        logic             up;
        logic             once;
        logic             hit;
        logic [CNT_W-1:0] rd_cnt;
        logic [1:0]       rd_unit;
        logic             rd_up;
        logic             flag;
    } token_t;

endpackage
`default_nettype wire

[rtl/core/mcstb_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
module mcstb_cell #(
    parameter int unsigned CELL_ID = 0
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  mcstb_pkg::token_t    tok_in,
    output mcstb_pkg::token_t    tok_out
);
    import mcstb_pkg::*;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] rel_reg, rel_next;
    logic [1:0]       unit_reg, unit_next;
    logic             up_reg, up_next;
    logic             once_reg, once_next;
    logic             run_reg, run_next;
    logic             flag_reg, flag_next;
    token_t           tok_reg, tok_next;
    logic             match;

    assign match = (CELL_ID < IDX_SPAN) && (tok_in.idx == IDX_W'(CELL_ID));
    assign tok_out = tok_reg;

    always_comb begin
        cnt_next = cnt_reg;
        rel_next = rel_reg;
        unit_next = unit_reg;
        up_next = up_reg;
        once_next = once_reg;
        run_next = run_reg;
        flag_next = flag_reg;
        tok_next = tok_in;
        if (tok_in.valid) begin
            if (tok_in.op == OP_TICK) begin
                if (run_reg) begin
                    if (up_reg && (cnt_reg < rel_reg)) begin
                        cnt_next = cnt_reg + 1'b1;
                    end else if (!up_reg && (cnt_reg != '0)) begin
                        cnt_next = cnt_reg - 1'b1;
                    end else begin
                        flag_next = 1'b1;
                        if (once_reg) begin
                            run_next = 1'b0;
                        end else begin
                            cnt_next = up_reg ? '0 : rel_reg;
                        end
                    end
                end
            end else if (match) begin
                case (tok_in.op) inside
                    OP_START, OP_INIT: begin
                        cnt_next = tok_in.cnt;
                        rel_next = tok_in.rel;
                        unit_next = tok_in.unit;
                        up_next = tok_in.up;
                        once_next = tok_in.once;
                        run_next = (tok_in.op == OP_START);
                        flag_next = 1'b0;
                    end
                    OP_SET: cnt_next = tok_in.cnt;
                    OP_PAUSE: run_next = 1'b0;
                    OP_PLAY: run_next = 1'b1;
                    OP_READ: begin
                        tok_next.hit = 1'b1;
                        tok_next.rd_cnt = cnt_reg;
                        tok_next.rd_unit = unit_reg;
                        tok_next.rd_up = up_reg;
                    end
                    OP_READ_CLR: begin
                        tok_next.flag = flag_reg;
                        flag_next = 1'b0;
                    end
                    OP_RAISE: flag_next = 1'b1;
                    OP_CLEAR: flag_next = 1'b0;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rel_reg <= '0;
            unit_reg <= '0;
            up_reg <= 1'b0;
            once_reg <= 1'b0;
            run_reg <= 1'b0;
            flag_reg <= 1'b0;
            tok_reg.valid <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            rel_reg <= rel_next;
            unit_reg <= unit_next;
            up_reg <= up_next;
            once_reg <= once_next;
            run_reg <= run_next;
            flag_reg <= flag_next;
            tok_reg.valid <= tok_next.valid;
        end
        tok_reg.op <= tok_next.op;
        tok_reg.idx <= tok_next.idx;
        tok_reg.cnt <= tok_next.cnt;
        tok_reg.rel <= tok_next.rel;
        tok_reg.unit <= tok_next.unit;
        tok_reg.up <= tok_next.up;
        tok_reg.once <= tok_next.once;
        tok_reg.hit <= tok_next.hit;
        tok_reg.rd_cnt <= tok_next.rd_cnt;
        tok_reg.rd_unit <= tok_next.rd_unit;
        tok_reg.rd_up <= tok_next.rd_up;
        tok_reg.flag <= tok_next.flag;
    end

endmodule
`default_nettype wire

[rtl/core/mcstb_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module mcstb_div (
    input  wire                               aclk,
    input  wire                               aresetn,
    input  wire                               start,
    input  wire  [mcstb_pkg::CNT_W-1:0]       dividend,
    input  wire  [mcstb_pkg::TICK_W-1:0]      divisor,
    output logic                              done,
    output logic [mcstb_pkg::CNT_W-1:0]       quotient
);
    import mcstb_pkg::*;

    logic [CNT_W-1:0]  acc_reg, acc_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [TICK_W-1:0] den_reg, den_next;
    logic [4:0]        step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W:0]    trial;

    assign trial = {rem_reg, acc_reg[CNT_W-1]} - (CNT_W+1)'(den_reg);
    assign done = done_reg;
    assign quotient = acc_reg;

    always_comb begin
        acc_next = acc_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            acc_next = dividend;
            rem_next = '0;
            den_next = divisor;
            step_next = '1;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[CNT_W]) begin
                rem_next = trial[CNT_W-1:0];
                acc_next = {acc_reg[CNT_W-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[CNT_W-2:0], acc_reg[CNT_W-1]};
                acc_next = {acc_reg[CNT_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        step_reg <= step_next;
    end

endmodule
`default_nettype wire

[rtl/core/multi_channel_soft_timer_bank.sv]
// Bank of software timers driven by one opcode transaction at a time.
// s_axis: one opcode transaction (tick, start, init, set, pause, play, read,
//   read-clear, raise, clear) per tdata word; every transaction yields exactly
//   one m_axis transaction carrying read_value and flag_was_set.
// APB: four ticks-per-unit registers at byte addresses 0, 4, 8, 12.
// The timer entries sit in a chain of NUM_TIMERS cells; a transaction travels
// the chain one cell per cycle.
// Start, init and set of a timer in range first pass the MUL0, MUL1 and MUL2
// states, which scale the start and limit values in 32x24 multiplies, and a
// read that hits a timer then passes through a radix-2 divider. One item is
// in flight at a time: s_tready returns in the cycle after the result is
// taken, so a new item is accepted only once the last one is done.
// Reset clears every timer entry (stopped, flags low) and restores the unit
// registers to 8, 80, 800 and 8000.
// A stalled m_axis holds its result and s_tready stays low until it is taken.
`timescale 1ns / 1ps
`default_nettype none
`include "multi_channel_soft_timer_bank_defines.svh"
module multi_channel_soft_timer_bank #(
    parameter int unsigned NUM_TIMERS = mcstb_pkg::DEF_NUM_TIMERS
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    // opcode[3:0], timer_index[6:4], start_value[38:7], limit_units[70:39],
    // unit_code[72:71], dir_up[73], one_shot[74], zero[79:75]
    input  wire  [79:0] s_tdata,
    output logic        m_tvalid,
    input  wire         m_tready,
    // read_value[31:0], flag_was_set[32], zero[39:33]
    output logic [39:0] m_tdata,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [3:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mcstb_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MUL0  = 7'b0000010,
        ST_MUL1  = 7'b0000100,
        ST_MUL2  = 7'b0001000,
        ST_CHAIN = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [TICK_W-1:0] ticks_reg [NUM_UNITS];
    logic [1:0]        sh_unit_reg [IDX_SPAN];
    logic              sh_up_reg [IDX_SPAN];
    token_t            tok_reg, tok_next;
    token_t            tok_chain [NUM_TIMERS+1];
    logic [CNT_W-1:0]  sv_reg, uv_reg, prod_reg, prod_next;
    logic [CNT_W-1:0]  adj;
    logic [TICK_W-1:0] t_sel;
    logic [CNT_W-1:0]  rv_reg, rv_next;
    logic              fl_reg, fl_next;
    logic              div_start, div_done;
    logic [CNT_W-1:0]  div_q, div_n;
    logic [TICK_W-1:0] div_d;
    logic              cfg_wr, in_range;
    logic [1:0]        in_unit;
    logic              in_up;
    logic [3:0]        in_op;
    logic [IDX_W-1:0]  in_idx;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = 32'(ticks_reg[paddr[3:2]]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ticks_reg[0] <= TICKS_RST_0;
            ticks_reg[1] <= TICKS_RST_1;
            ticks_reg[2] <= TICKS_RST_2;
            ticks_reg[3] <= TICKS_RST_3;
        end else if (cfg_wr) begin
            ticks_reg[paddr[3:2]] <= pwdata[TICK_W-1:0];
        end
    end

    assign in_op = s_tdata[3:0];
    assign in_idx = s_tdata[6:4];
    assign in_range = (32'(in_idx) < NUM_TIMERS);
    assign in_unit = (in_op == OP_SET) ? sh_unit_reg[in_idx] : s_tdata[72:71];
    assign in_up = (in_op == OP_SET) ? sh_up_reg[in_idx] : s_tdata[73];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < IDX_SPAN; i++) begin
                sh_unit_reg[i] <= '0;
                sh_up_reg[i] <= 1'b0;
            end
        end else if (s_tvalid && s_tready && in_range
                     && (in_op == OP_START || in_op == OP_INIT)) begin
            sh_unit_reg[in_idx] <= s_tdata[72:71];
            sh_up_reg[in_idx] <= s_tdata[73];
        end
    end

    assign t_sel = ticks_reg[tok_reg.unit];
    assign adj = tok_reg.up ? prod_reg : prod_reg + CNT_W'(t_sel) - 1'b1;

    assign tok_chain[0] = tok_reg;
    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
        mcstb_cell #(.CELL_ID(g)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .tok_in  (tok_chain[g]),
            .tok_out (tok_chain[g+1])
        );
    end

    assign div_n = tok_chain[NUM_TIMERS].rd_up ? tok_chain[NUM_TIMERS].rd_cnt
                                                : tok_chain[NUM_TIMERS].rd_cnt + 1'b1;
    assign div_d = ticks_reg[tok_chain[NUM_TIMERS].rd_unit];

    mcstb_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (div_q)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata = {7'b0, fl_reg, rv_reg};

    always_comb begin
        state_next = state_reg;
        tok_next = tok_reg;
        tok_next.valid = 1'b0;
        prod_next = prod_reg;
        rv_next = rv_reg;
        fl_next = fl_reg;
        div_start = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    tok_next.op = in_op;
                    tok_next.idx = in_range ? in_idx : '1;
                    tok_next.unit = in_unit;
                    tok_next.up = in_up;
                    tok_next.once = s_tdata[74];
                    tok_next.hit = 1'b0;
                    tok_next.flag = 1'b0;
                    tok_next.rd_cnt = '0;
                    tok_next.rd_unit = '0;
                    tok_next.rd_up = 1'b0;
                    if (!in_range && in_op != OP_TICK) begin
                        tok_next.op = OP_NOP;
                    end
                    if (in_range && (in_op == OP_START || in_op == OP_INIT
                                     || in_op == OP_SET)) begin
                        state_next = ST_MUL0;
                    end else begin
                        tok_next.valid = 1'b1;
                        state_next = ST_CHAIN;
                    end
                end
            end
            ST_MUL0: begin
                prod_next = CNT_W'(sv_reg * CNT_W'(t_sel));
                state_next = ST_MUL1;
            end
            ST_MUL1: begin
                tok_next.cnt = adj;
                prod_next = CNT_W'(uv_reg * CNT_W'(t_sel));
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                tok_next.rel = adj;
                tok_next.valid = 1'b1;
                state_next = ST_CHAIN;
            end
            ST_CHAIN: begin
                if (tok_chain[NUM_TIMERS].valid) begin
                    rv_next = '0;
                    fl_next = tok_chain[NUM_TIMERS].flag;
                    if (tok_chain[NUM_TIMERS].op == OP_READ && tok_chain[NUM_TIMERS].hit) begin
                        div_start = 1'b1;
                        state_next = ST_DIV;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    rv_next = div_q;
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            tok_reg.valid <= 1'b0;
        end else begin
            state_reg <= state_next;
            tok_reg.valid <= tok_next.valid;
        end
        tok_reg.op <= tok_next.op;
        tok_reg.idx <= tok_next.idx;
        tok_reg.cnt <= tok_next.cnt;
        tok_reg.rel <= tok_next.rel;
        tok_reg.unit <= tok_next.unit;
        tok_reg.up <= tok_next.up;
        tok_reg.once <= tok_next.once;
        tok_reg.hit <= tok_next.hit;
        tok_reg.rd_cnt <= tok_next.rd_cnt;
        tok_reg.rd_unit <= tok_next.rd_unit;
        tok_reg.rd_up <= tok_next.rd_up;
        tok_reg.flag <= tok_next.flag;
        prod_reg <= prod_next;
        rv_reg <= rv_next;
        fl_reg <= fl_next;
        if (s_tvalid && s_tready) begin
            sv_reg <= s_tdata[38:7];
            uv_reg <= s_tdata[70:39];
        end
    end

    `MCSTB_ASSERT_NEVER(a_no_overlap, s_tready && m_tvalid)
    `MCSTB_ASSERT_IMPL(a_div_in_div, div_done, state_reg == ST_DIV)
    `MCSTB_ASSERT_IMPL(a_chain_idle, state_reg == ST_DIV, !tok_chain[NUM_TIMERS].valid)

endmodule
`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
    import mcstb_pkg::*;

    localparam int NT = 8;
    localparam int LIMIT_CYCLES = 900000;

    typedef struct packed {
        logic [31:0] read_value;
        logic        flag_was_set;
    } timer_result_t;

    class timer_scoreboard;
        logic [23:0]   unit_ticks [4];
        logic [31:0]   tick_count [NT];
        logic [31:0]   reload_count [NT];
        logic [1:0]    unit_sel [NT];
        logic          up_mode [NT];
        logic          single_shot [NT];
        logic          running [NT];
        logic          timeout_flag [NT];
        timer_result_t pending_results [$];
        int            errors;

        function new();
            unit_ticks[0] = TICKS_RST_0;
            unit_ticks[1] = TICKS_RST_1;
            unit_ticks[2] = TICKS_RST_2;
            unit_ticks[3] = TICKS_RST_3;
            for (int i = 0; i < NT; i++) begin
                tick_count[i] = 0;
                reload_count[i] = 0;
                unit_sel[i] = 0;
                up_mode[i] = 0;
                single_shot[i] = 0;
                running[i] = 0;
                timeout_flag[i] = 0;
            end
            errors = 0;
        endfunction

        function logic [31:0] units_to_ticks(logic [31:0] v, logic [1:0] u, logic up);
            logic [31:0] t;
            t = {8'd0, unit_ticks[u]};
            return up ? v * t : (v + 32'd1) * t - 32'd1;
        endfunction

        function void step_all();
            for (int i = 0; i < NT; i++) begin
                if (!running[i]) continue;
                if (up_mode[i] && tick_count[i] < reload_count[i]) begin
                    tick_count[i]++;
                    continue;
                end
                if (!up_mode[i] && tick_count[i] != 0) begin
                    tick_count[i]--;
                    continue;
                end
                timeout_flag[i] = 1;
                if (single_shot[i]) running[i] = 0;
                else tick_count[i] = up_mode[i] ? 32'd0 : reload_count[i];
            end
        endfunction

        function void note_command(logic [79:0] d);
            logic [3:0]    op;
            int            ix;
            logic [31:0]   sv, uv, n, t;
            logic [1:0]    u;
            timer_result_t r;
            op = d[3:0];
            ix = d[6:4];
            sv = d[38:7];
            uv = d[70:39];
            u = d[72:71];
            r = '0;
            if (op == OP_TICK) begin
                step_all();
            end else if (ix < NT) begin
                case (op)
                    OP_START, OP_INIT: begin
                        tick_count[ix] = units_to_ticks(sv, u, d[73]);
                        reload_count[ix] = units_to_ticks(uv, u, d[73]);
                        unit_sel[ix] = u;
                        up_mode[ix] = d[73];
                        single_shot[ix] = d[74];
                        running[ix] = (op == OP_START);
                        timeout_flag[ix] = 0;
                    end
                    OP_SET: tick_count[ix] = units_to_ticks(sv, unit_sel[ix], up_mode[ix]);
                    OP_PAUSE: running[ix] = 0;
                    OP_PLAY: running[ix] = 1;
                    OP_READ: begin
                        t = {8'd0, unit_ticks[unit_sel[ix]]};
                        n = up_mode[ix] ? tick_count[ix] : tick_count[ix] + 32'd1;
                        r.read_value = (t == 0) ? 32'hFFFF_FFFF : n / t;
                    end
                    OP_READ_CLR: begin
                        r.flag_was_set = timeout_flag[ix];
                        timeout_flag[ix] = 0;
                    end
                    OP_RAISE: timeout_flag[ix] = 1;
                    OP_CLEAR: timeout_flag[ix] = 0;
                    default: ;
                endcase
            end
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [39:0] d);
            timer_result_t e;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, d);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (d[31:0] !== e.read_value) begin
                $display("%0t: read_value expected %h actual %h", $time, e.read_value, d[31:0]);
                errors++;
            end
            if (d[32] !== e.flag_was_set) begin
                $display("%0t: flag_was_set expected %b actual %b",
                         $time, e.flag_was_set, d[32]);
                errors++;
            end
            if (d[39:33] !== 7'd0) begin
                $display("%0t: pad expected 0 actual %h", $time, d[39:33]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    timer_scoreboard scb;
    int  cycle_count;
    bit  rx_idle_en;
    bit  up_bias;

    multi_channel_soft_timer_bank uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial begin
        aclk = 0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) scb.check_result(m_tdata);
    end

    initial begin
        int w;
        m_tready = 0;
        @(posedge aclk);
        while (1) begin
            w = rx_idle_en ? $urandom_range(0, 15) : 0;
            if ($urandom_range(0, 3) == 0) w = 0;
            if (w > 0) begin
                m_tready <= 0;
                repeat (w) @(posedge aclk);
            end
            m_tready <= 1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    task automatic reg_write(input int ix, input logic [31:0] v);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= 4'(4 * ix);
        pwdata <= v;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        scb.unit_ticks[ix] = v[23:0];
        @(posedge aclk);
    endtask

    task automatic send_command(input logic [3:0] op, input logic [2:0] ix,
                                input logic [31:0] sv, input logic [31:0] uv,
                                input logic [1:0] u, input logic up, input logic once,
                                input bit gap);
        int w;
        w = gap ? $urandom_range(0, 15) : 0;
        if (gap && $urandom_range(0, 3) == 0) w = 0;
        if (w > 0) begin
            s_tvalid <= 0;
            repeat (w) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {5'd0, once, up, u, uv, sv, ix, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        scb.note_command({5'd0, once, up, u, uv, sv, ix, op});
    endtask

    task automatic drain();
        s_tvalid <= 0;
        while (scb.pending_results.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic random_command(input int small_max);
        logic [3:0]  op;
        logic [31:0] sv, uv;
        int          k;
        k = $urandom_range(0, 99);
        if (k < 40) op = OP_TICK;
        else if (k < 90) op = 4'($urandom_range(1, 9));
        else op = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 9) == 0) begin
            sv = $urandom;
            uv = $urandom;
        end else begin
            sv = $urandom_range(0, small_max);
            uv = $urandom_range(0, small_max);
        end
        send_command(op, 3'($urandom), sv, uv, 2'($urandom),
                     up_bias ? ($urandom_range(0, 3) != 0) : 1'($urandom),
                     1'($urandom), 1'b1);
    endtask

    initial begin
        scb = new();
        cycle_count = 0;
        rx_idle_en = 1;
        up_bias = 0;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = '0;
        pwdata = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        send_command(OP_READ, 0, 0, 0, 0, 0, 0, 0);
        send_command(OP_START, 0, 0, 32'hFFFF_FFFF, 2'd3, 0, 0, 0);
        send_command(OP_INIT, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd0, 1, 1, 0);
        send_command(OP_START, 1, 1, 2, 2'd0, 1, 1, 0);
        send_command(OP_START, 2, 0, 1, 2'd1, 0, 0, 0);
        for (int i = 0; i < 20; i++) send_command(OP_TICK, 0, 0, 0, 0, 0, 0, 0);
        send_command(OP_READ, 1, 0, 0, 0, 0, 0, 0);
        send_command(OP_READ_CLR, 1, 0, 0, 0, 0, 0, 0);
        send_command(OP_SET, 2, 3, 0, 0, 0, 0, 0);
        send_command(OP_READ, 2, 0, 0, 0, 0, 0, 0);
        send_command(OP_PAUSE, 2, 0, 0, 0, 0, 0, 0);
        send_command(OP_PLAY, 2, 0, 0, 0, 0, 0, 0);
        send_command(OP_RAISE, 3, 0, 0, 0, 0, 0, 0);
        send_command(OP_READ_CLR, 3, 0, 0, 0, 0, 0, 0);
        send_command(OP_CLEAR, 2, 0, 0, 0, 0, 0, 0);
        send_command(OP_READ_CLR, 2, 0, 0, 0, 0, 0, 0);
        send_command(OP_NOP, 5, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 2'd3, 1, 1, 0);
        send_command(OP_READ, 7, 0, 0, 0, 0, 0, 0);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: for (int r = 0; r < 4; r++) reg_write(r, 32'd1);
                1: for (int r = 0; r < 4; r++) reg_write(r, 32'hFFFF_FFFF);
                2: for (int r = 0; r < 4; r++) reg_write(r, $urandom_range(1, 5));
                3: for (int r = 0; r < 4; r++) reg_write(r, $urandom);
                4: begin
                    reg_write(0, 32'd1);
                    reg_write(1, 32'd2);
                    reg_write(2, 32'd3);
                    reg_write(3, 32'h00FF_FFFF);
                end
                default: for (int r = 0; r < 4; r++) reg_write(r, $urandom_range(1, 16));
            endcase
            up_bias = phase[0];
            rx_idle_en = (phase != 4);
            for (int n = 0; n < 300; n++) begin
                random_command(phase == 1 || phase == 3 ? 40 : 6);
                if (phase == 2 && n == 150) drain();
            end
            drain();
        end

        s_tvalid <= 0;
        while (scb.pending_results.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        if (scb.errors == 0 && scb.pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

[multi_channel_soft_timer_bank.f]
+incdir+rtl/core
rtl/core/mcstb_pkg.sv
rtl/core/mcstb_cell.sv
rtl/core/mcstb_div.sv
rtl/core/multi_channel_soft_timer_bank.sv
sim/tb_top.sv
